FILE: design/stop_and_wait_arq_sender_top_macros.svh
// ----------------------------------------------------------------------------
// stop-and-wait arq sender assertion macros
// shared property wrappers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_SENDER_TOP_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_TOP_MACROS_SVH

// same-cycle implication
`define SWARQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swarq: same-cycle check failed");

// next-cycle implication
`define SWARQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swarq: next-cycle check failed");

`endif

FILE: design/swarq_pkg.sv
// ----------------------------------------------------------------------------
// swarq_pkg
// types and constants of the stop-and-wait arq sender
// ----------------------------------------------------------------------------
package swarq_pkg;

  localparam int unsigned SeqW     = 16;
  localparam int unsigned AttW     = 4;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ToW      = 17;
  localparam int unsigned OpW      = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ActW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [OpW-1:0] {
    OP_START       = 2'd0,
    OP_SEND_RESULT = 2'd1,
    OP_RX_FRAME    = 2'd2,
    OP_TICK        = 2'd3
  } op_e;

  localparam logic [KindW-1:0] RX_KIND_ACK  = 2'd1;
  localparam logic [KindW-1:0] RX_KIND_NACK = 2'd2;

  typedef enum logic [ActW-1:0] {
    ACT_TRANSMIT = 2'd0,
    ACT_SUCCESS  = 2'd1,
    ACT_FAILURE  = 2'd2
  } act_e;

  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_TIMEOUT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPI_TIMEOUT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXTRA_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LATENCY_THR   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPI_MODE      = 3'd5;

  localparam logic [AttW-1:0] RST_MAX_ATTEMPTS  = 4'd3;
  localparam logic [MsW-1:0]  RST_BASE_TIMEOUT  = 16'd1000;
  localparam logic [MsW-1:0]  RST_SPI_TIMEOUT   = 16'd1500;
  localparam logic [MsW-1:0]  RST_EXTRA_TIMEOUT = 16'd1000;
  localparam logic [MsW-1:0]  RST_LATENCY_THR   = 16'd100;

  localparam logic [ToW-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [AttW-1:0] max_attempts;
    logic [MsW-1:0]  base_timeout_ms;
    logic [MsW-1:0]  spi_timeout_ms;
    logic [MsW-1:0]  extra_timeout_ms;
    logic [MsW-1:0]  latency_threshold_ms;
    logic            spi_mode;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [SeqW-1:0]  seq;
    logic             send_ok;
    logic             rx_valid;
    logic [KindW-1:0] rx_kind;
    logic [MsW-1:0]   avg_latency_ms;
  } in_item_t;

  typedef struct packed {
    act_e            action;
    logic [SeqW-1:0] out_seq;
    logic [AttW-1:0] attempts_left;
    logic [ToW-1:0]  timeout_used;
  } out_item_t;

endpackage

FILE: design/swarq_cfg.sv
// ----------------------------------------------------------------------------
// swarq_cfg
// configuration register bank, written by index
// ----------------------------------------------------------------------------
module swarq_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swarq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swarq_pkg::CfgDataW-1:0] cfg_data_i,
  output swarq_pkg::cfg_t                cfg_o
);
  import swarq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ATTEMPTS:  cfg_d.max_attempts         = cfg_data_i[AttW-1:0];
        CFG_BASE_TIMEOUT:  cfg_d.base_timeout_ms      = cfg_data_i[MsW-1:0];
        CFG_SPI_TIMEOUT:   cfg_d.spi_timeout_ms       = cfg_data_i[MsW-1:0];
        CFG_EXTRA_TIMEOUT: cfg_d.extra_timeout_ms     = cfg_data_i[MsW-1:0];
        CFG_LATENCY_THR:   cfg_d.latency_threshold_ms = cfg_data_i[MsW-1:0];
        CFG_SPI_MODE:      cfg_d.spi_mode             = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts         <= RST_MAX_ATTEMPTS;
      cfg_q.base_timeout_ms      <= RST_BASE_TIMEOUT;
      cfg_q.spi_timeout_ms       <= RST_SPI_TIMEOUT;
      cfg_q.extra_timeout_ms     <= RST_EXTRA_TIMEOUT;
      cfg_q.latency_threshold_ms <= RST_LATENCY_THR;
      cfg_q.spi_mode             <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/swarq_core.sv
// ----------------------------------------------------------------------------
// swarq_core
// input register, exchange state update and result register
// ----------------------------------------------------------------------------
module swarq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swarq_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swarq_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swarq_pkg::out_item_t out_item_o
);
  import swarq_pkg::*;

  `include "stop_and_wait_arq_sender_top_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE      = 3'b001,
    ST_WAIT_SEND = 3'b010,
    ST_WAIT_ACK  = 3'b100
  } state_e;

  // input stage
  logic     in_valid_q, in_valid_d;
  in_item_t in_q, in_d;

  // exchange state
  state_e          state_q, state_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [AttW-1:0] rem_q, rem_d;
  logic [ToW-1:0]  elapsed_q, elapsed_d;
  logic [ToW-1:0]  timeout_q, timeout_d;

  // result stage
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic            res_valid;
  act_e            res_act;
  logic            advance;
  logic            out_free;
  logic [ToW-1:0]  start_timeout;
  logic [ToW-1:0]  elapsed_inc;
  logic [AttW-1:0] rem_dec;

  assign out_free = !out_valid_q || out_ready_i;

  // start timeout: mode base plus the high-latency extra
  always_comb begin
    start_timeout = {1'b0, (cfg_i.spi_mode ? cfg_i.spi_timeout_ms : cfg_i.base_timeout_ms)};
    if (in_q.avg_latency_ms > cfg_i.latency_threshold_ms) begin
      start_timeout = start_timeout + {1'b0, cfg_i.extra_timeout_ms};
    end
  end

  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
  assign rem_dec     = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

  always_comb begin
    state_d   = state_q;
    seq_d     = seq_q;
    rem_d     = rem_q;
    elapsed_d = elapsed_q;
    timeout_d = timeout_q;
    res_valid = 1'b0;
    res_act   = ACT_TRANSMIT;
    case (in_q.op)
      OP_START: begin
        seq_d     = in_q.seq;
        timeout_d = start_timeout;
        rem_d     = cfg_i.max_attempts;
        elapsed_d = '0;
        res_valid = 1'b1;
        if (cfg_i.max_attempts == '0) begin
          state_d = ST_IDLE;
          res_act = ACT_FAILURE;
        end else begin
          state_d = ST_WAIT_SEND;
          res_act = ACT_TRANSMIT;
        end
      end
      OP_SEND_RESULT: begin
        if (state_q == ST_WAIT_SEND) begin
          elapsed_d = '0;
          if (in_q.send_ok) begin
            state_d = ST_WAIT_ACK;
          end else begin
            rem_d     = rem_dec;
            res_valid = 1'b1;
            res_act   = (rem_dec == '0) ? ACT_FAILURE : ACT_TRANSMIT;
            state_d   = (rem_dec == '0) ? ST_IDLE : ST_WAIT_SEND;
          end
        end
      end
      OP_RX_FRAME: begin
        if (state_q == ST_WAIT_ACK && in_q.rx_valid && in_q.seq == seq_q) begin
          if (in_q.rx_kind == RX_KIND_ACK) begin
            state_d   = ST_IDLE;
            res_valid = 1'b1;
            res_act   = ACT_SUCCESS;
          end else if (in_q.rx_kind == RX_KIND_NACK) begin
            rem_d     = rem_dec;
            elapsed_d = '0;
            res_valid = 1'b1;
            res_act   = (rem_dec == '0) ? ACT_FAILURE : ACT_TRANSMIT;
            state_d   = (rem_dec == '0) ? ST_IDLE : ST_WAIT_SEND;
          end
        end
      end
      OP_TICK: begin
        if (state_q == ST_WAIT_ACK) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            rem_d     = rem_dec;
            elapsed_d = '0;
            res_valid = 1'b1;
            res_act   = (rem_dec == '0) ? ACT_FAILURE : ACT_TRANSMIT;
            state_d   = (rem_dec == '0) ? ST_IDLE : ST_WAIT_SEND;
          end
        end
      end
      default: ;
    endcase
  end

  // an item without a result never waits on the output side
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      in_d       = in_item_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance && res_valid) begin
      out_valid_d         = 1'b1;
      out_d.action        = res_act;
      out_d.out_seq       = seq_d;
      out_d.attempts_left = rem_d;
      out_d.timeout_used  = timeout_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_IDLE;
      seq_q       <= '0;
      rem_q       <= '0;
      elapsed_q   <= '0;
      timeout_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q   <= state_d;
        seq_q     <= seq_d;
        rem_q     <= rem_d;
        elapsed_q <= elapsed_d;
        timeout_q <= timeout_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SWARQ_ASSERT_NOW(a_active_has_budget, state_q != ST_IDLE, rem_q != '0)
  // an acknowledge leaves the count where it stood, still below the timeout
  `SWARQ_ASSERT_NOW(a_elapsed_bounded, 1'b1,
                    (elapsed_q == '0) || (elapsed_q < timeout_q))
  `SWARQ_ASSERT_NOW(a_failure_empty, out_valid_q && out_q.action == ACT_FAILURE,
                    out_q.attempts_left == '0)
  `SWARQ_ASSERT_NEXT(a_blocked_item_held,
                     in_valid_q && res_valid && out_valid_q && !out_ready_i,
                     in_valid_q && $stable(in_q))

endmodule

FILE: design/stop_and_wait_arq_sender_top.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_top
// sender side of a stop-and-wait exchange with retries and dynamic timeout
// ----------------------------------------------------------------------------
// usage
//   s_axis carries events: tuser selects start, send outcome, received frame
//   or millisecond tick; tdata carries the event fields.
//   m_axis carries transmit requests, success and failure reports; tuser
//   holds the action, tdata the sequence number, attempts left and timeout.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the six settings, only while idle;
//   they take effect at the next start item.
// timing
//   one item enters per cycle while s_axis_tready_o is high; an item passes
//   the input register, then its result the result register. the state update
//   of each item sits in one short compare-and-add path between those two registers.
// reset
//   the exchange returns to idle, both stages empty, settings to defaults.
// stall
//   a waiting result holds on m_axis; items that give no result keep flowing,
//   and the first one that would give a result waits in the input register,
//   which drops s_axis_tready_o until the result register drains.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [swarq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swarq_pkg::CfgDataW-1:0] cfg_data_i,
  // event stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // seq, send_ok, rx_valid, rx_kind, avg_latency_ms, zero pad
  input  logic [swarq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op
  input  logic [swarq_pkg::OpW-1:0]      s_axis_tuser_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_seq, attempts_left, timeout_used, zero pad
  output logic [swarq_pkg::OutDataW-1:0] m_axis_tdata_o,
  // action
  output logic [swarq_pkg::ActW-1:0]     m_axis_tuser_o
);
  import swarq_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  out_item_t out_item;

  always_comb begin
    in_item.op             = op_e'(s_axis_tuser_i);
    in_item.seq            = s_axis_tdata_i[15:0];
    in_item.send_ok        = s_axis_tdata_i[16];
    in_item.rx_valid       = s_axis_tdata_i[17];
    in_item.rx_kind        = s_axis_tdata_i[19:18];
    in_item.avg_latency_ms = s_axis_tdata_i[35:20];
  end

  swarq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swarq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (out_item)
  );

  assign m_axis_tuser_o = out_item.action;
  assign m_axis_tdata_o = {3'b000, out_item.timeout_used, out_item.attempts_left,
                           out_item.out_seq};

endmodule
